@@ hw/rtl/url_enc_pkg.sv @@
// Shared types, constants and character helpers for the form-URL byte encoder.
// Depends on nothing; every other file in the block imports this package.
package url_enc_pkg;

    // Field and state widths.
    localparam int ByteW  = 8;
    localparam int CapW   = 13;
    localparam int CountW = 12;

    // Largest buffer capacity honored; larger settings saturate to it.
    localparam logic [CapW-1:0] MAX_CAPACITY  = 13'd4096;
    localparam logic [CapW-1:0] CAPACITY_INIT = 13'd256;

    // Characters with a fixed role in the encoding.
    localparam logic [ByteW-1:0] CH_DASH    = 8'h2D;
    localparam logic [ByteW-1:0] CH_UNDER   = 8'h5F;
    localparam logic [ByteW-1:0] CH_DOT     = 8'h2E;
    localparam logic [ByteW-1:0] CH_TILDE   = 8'h7E;
    localparam logic [ByteW-1:0] CH_SPACE   = 8'h20;
    localparam logic [ByteW-1:0] CH_PLUS    = 8'h2B;
    localparam logic [ByteW-1:0] CH_PERCENT = 8'h25;
    localparam logic [ByteW-1:0] CH_ZERO    = 8'h30;
    localparam logic [ByteW-1:0] CH_NINE    = 8'h39;
    localparam logic [ByteW-1:0] CH_UA      = 8'h41;
    localparam logic [ByteW-1:0] CH_UF      = 8'h46;
    localparam logic [ByteW-1:0] CH_UZ      = 8'h5A;
    localparam logic [ByteW-1:0] CH_LA      = 8'h61;
    localparam logic [ByteW-1:0] CH_LZ      = 8'h7A;
    localparam logic [ByteW-1:0] CH_NUL     = 8'h00;

    // Up to three output bytes for one input byte, first byte in slot 0.
    typedef struct packed {
        logic [1:0]                num;
        logic [2:0][ByteW-1:0]     bytes;
    } res_t;

    // Letters, digits and the four unreserved marks pass unchanged.
    function automatic logic is_plain(input logic [ByteW-1:0] b);
        logic digit;
        logic upper;
        logic lower;
        logic mark;
        digit = (b >= CH_ZERO) && (b <= CH_NINE);
        upper = (b >= CH_UA) && (b <= CH_UZ);
        lower = (b >= CH_LA) && (b <= CH_LZ);
        mark  = (b == CH_DASH) || (b == CH_UNDER) || (b == CH_DOT) || (b == CH_TILDE);
        return digit || upper || lower || mark;
    endfunction

    // Upper-case hex digit for one nibble.
    function automatic logic [ByteW-1:0] hex_digit(input logic [3:0] nib);
        logic [ByteW-1:0] ext;
        ext = {4'd0, nib};
        if (nib < 4'd10) begin
            return CH_ZERO + ext;
        end
        return CH_UA + ext - 8'd10;
    endfunction

endpackage

@@ hw/rtl/url_enc_encode.sv @@
// Encode stage: classifies one byte, checks room in the buffer and keeps the
// running count of bytes written. Depends on url_enc_pkg.
module url_enc_encode
    import url_enc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [ByteW-1:0] char_in,
    input  logic [CapW-1:0]  capacity_in,
    output res_t             res
);

    logic [CountW-1:0] written_count_reg;
    logic [CountW-1:0] written_count_next;
    logic [CapW-1:0]   cap_eff;
    logic [CapW-1:0]   count_ext;

    // Clamp the configured capacity into its working range.
    always_comb
    begin
        if (capacity_in == '0) begin
            cap_eff = {{(CapW-1){1'b0}}, 1'b1};
        end else if (capacity_in > MAX_CAPACITY) begin
            cap_eff = MAX_CAPACITY;
        end else begin
            cap_eff = capacity_in;
        end
    end

    assign count_ext = {1'b0, written_count_reg};

    // Decide how many bytes this character produces and what they are.
    always_comb
    begin
        res.num            = 2'd0;
        res.bytes          = '0;
        written_count_next = written_count_reg;
        if (char_in == CH_NUL) begin
            res.num            = 2'd1;
            res.bytes[0]       = CH_NUL;
            written_count_next = '0;
        end else if (count_ext + 13'd1 >= cap_eff) begin
            res.num = 2'd0;
        end else if (is_plain(char_in)) begin
            res.num            = 2'd1;
            res.bytes[0]       = char_in;
            written_count_next = written_count_reg + 12'd1;
        end else if (char_in == CH_SPACE) begin
            res.num            = 2'd1;
            res.bytes[0]       = CH_PLUS;
            written_count_next = written_count_reg + 12'd1;
        end else if (count_ext + 13'd4 < cap_eff) begin
            res.num            = 2'd3;
            res.bytes[0]       = CH_PERCENT;
            res.bytes[1]       = hex_digit(char_in[7:4]);
            res.bytes[2]       = hex_digit(char_in[3:0]);
            written_count_next = written_count_reg + 12'd3;
        end
    end

    // The count advances only when the byte moves into the result buffer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            written_count_reg <= '0;
        end else if (fire) begin
            written_count_reg <= written_count_next;
        end
    end

endmodule

@@ hw/rtl/url_enc_outbuf.sv @@
// Result buffer: holds up to three encoded bytes and hands them out one per
// request, flagging the last one. Depends on url_enc_pkg.
module url_enc_outbuf
    import url_enc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  res_t             res,
    output logic             can_load,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [ByteW-1:0] out_byte,
    output logic             run_last
);

    logic [1:0]            cnt_reg;
    logic [2:0][ByteW-1:0] bytes_reg;
    logic                  take;

    assign take      = out_valid && !out_stall;
    assign out_valid = (cnt_reg != 2'd0);
    assign out_byte  = bytes_reg[0];
    assign run_last  = (cnt_reg == 2'd1);

    // Refill when empty or when the last pending byte leaves this cycle.
    assign can_load = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && !out_stall);

    // Pending byte count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= res.num;
        end else if (take) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Byte slots shift toward slot 0 as bytes are taken.
    always_ff @(posedge clk)
    begin
        if (load) begin
            bytes_reg <= res.bytes;
        end else if (take) begin
            bytes_reg <= {CH_NUL, bytes_reg[2], bytes_reg[1]};
        end
    end

endmodule

@@ hw/rtl/url_form_byte_encoder.sv @@
// Top level of the form-URL byte encoder: input register, capacity register,
// encode stage and result buffer. Depends on url_enc_pkg, url_enc_encode, url_enc_outbuf.
//
// One string byte per request goes in; its encoded form comes out one byte per
// request, with run_last high on the final byte of each input. Letters, digits
// and - _ . ~ give one byte, a space gives '+', other bytes give '%' and two
// hex digits, and a zero byte gives the terminator and restarts the count.
// Bytes that would overflow the configured capacity produce nothing. The first
// result byte is offered after its input has passed from the input register into
// the result buffer, which sets the throughput: it sends one byte per cycle while
// out_stall is low and takes the next input as its last byte leaves. The capacity
// register is always ready and should be written only while the block is idle.
module url_form_byte_encoder
    import url_enc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CapW-1:0]  capacity,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [ByteW-1:0] char_byte,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [ByteW-1:0] out_byte,
    output logic             run_last
);

    logic [CapW-1:0]  capacity_reg;
    logic [ByteW-1:0] char_reg;
    logic             full_reg;
    logic             can_load;
    logic             fire;
    logic             in_take;
    res_t             res;

    assign cfg_ready = 1'b1;
    assign fire      = full_reg && can_load;
    assign in_stall  = full_reg && !can_load;
    assign in_take   = in_valid && !in_stall;

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            capacity_reg <= CAPACITY_INIT;
        end else if (cfg_valid && cfg_ready) begin
            capacity_reg <= capacity;
        end
    end

    // Input register occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            full_reg <= 1'b0;
        end else if (in_take) begin
            full_reg <= 1'b1;
        end else if (fire) begin
            full_reg <= 1'b0;
        end
    end

    // Input byte capture.
    always_ff @(posedge clk)
    begin
        if (in_take) begin
            char_reg <= char_byte;
        end
    end

    url_enc_encode u_encode (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .char_in     (char_reg),
        .capacity_in (capacity_reg),
        .res         (res)
    );

    url_enc_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .res       (res),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

endmodule

@@ hw/rtl/url_enc_checker.sv @@
// Port-level checks for the form-URL byte encoder, bound to the top level.
// Depends on url_enc_pkg and url_form_byte_encoder.
module url_enc_checker
    import url_enc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_stall,
    input logic [ByteW-1:0] out_byte,
    input logic             run_last
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(run_last))
        else $error("stalled result changed");

    // A percent sign always opens a triple, so it is never the last byte.
    a_pct_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_byte == CH_PERCENT) |-> !run_last)
        else $error("percent sign flagged as last byte");

    // Bytes before the last of a run are a percent sign or upper-case hex digits.
    a_mid_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |->
            (out_byte == CH_PERCENT) ||
            ((out_byte >= CH_ZERO) && (out_byte <= CH_NINE)) ||
            ((out_byte >= CH_UA) && (out_byte <= CH_UF)))
        else $error("unexpected byte inside a percent triple");

    // The rest of a triple is already buffered when a non-last byte leaves.
    a_triple_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !run_last |=> out_valid)
        else $error("gap inside a percent triple");

endmodule

bind url_form_byte_encoder url_enc_checker u_url_enc_checker (.*);

@@ bench/url_form_byte_encoder_test.sv @@
// Self-checking bench for url_form_byte_encoder: a directed table, then random strings
// over a range of capacities. Depends on url_enc_pkg and the url_form_byte_encoder RTL.
module url_form_byte_encoder_test;
    import url_enc_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int TARGET_ITEMS = 420;
    localparam int PHASE_ITEMS  = 35;
    localparam int DIR_ROWS     = 23;
    localparam int EDGE_COUNT   = 10;
    localparam string PLAIN_SET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_.~";
    localparam string HEX_SET   = "0123456789ABCDEF";

    // Capacities visited first: zero, one, small values around the room for one triple, saturation.
    localparam logic [CapW-1:0] EDGE_CAPS [EDGE_COUNT] =
        '{13'd0, 13'd1, 13'd4, 13'd5, 13'd8191, 13'd2, 13'd3, 13'd6, 13'd4096, 13'd4097};

    // One expected output byte.
    typedef struct packed {
        logic [ByteW-1:0] ob;
        logic             last;
    } enc_out_t;

    // One row of the directed table; want is used only where typed is set.
    typedef struct packed {
        logic [ByteW-1:0] ch;
        logic             typed;
        res_t             want;
    } dir_row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CapW-1:0]  capacity;
    logic             in_valid;
    logic             in_stall;
    logic [ByteW-1:0] char_byte;
    logic             out_valid;
    logic             out_stall;
    logic [ByteW-1:0] out_byte;
    logic             run_last;

    // Encoder state as the bench sees it.
    logic [CapW-1:0]   pred_capacity;
    logic [CountW-1:0] pred_count;

    enc_out_t pending_bytes [$];
    dir_row_t dir_rows [DIR_ROWS];
    int       error_count;
    int       sent_items;
    int       cycle_count;
    int       send_gap;
    int       recv_pct;

    url_form_byte_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .capacity  (capacity),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_byte (char_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Builds an expected result from its count and bytes, first byte in slot 0.
    function automatic res_t mk_res(input int n, input logic [ByteW-1:0] b0,
                                    input logic [ByteW-1:0] b1, input logic [ByteW-1:0] b2);
        res_t r;
        r.num      = 2'(n);
        r.bytes[0] = b0;
        r.bytes[1] = b1;
        r.bytes[2] = b2;
        return r;
    endfunction

    // Letters, digits and the four marks are exactly the characters of PLAIN_SET.
    function automatic logic unreserved(input logic [ByteW-1:0] b);
        for (int i = 0; i < PLAIN_SET.len(); i++)
        begin
            if (PLAIN_SET[i] == b)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Encodes one string byte against the current capacity and advances the count.
    function automatic res_t encode_char(input logic [ByteW-1:0] b);
        res_t r;
        int   eff;
        int   cnt;
        r   = '0;
        eff = int'(pred_capacity);
        cnt = int'(pred_count);
        if (eff == 0)
            eff = 1;
        if (eff > int'(MAX_CAPACITY))
            eff = int'(MAX_CAPACITY);
        if (b == CH_NUL)
        begin
            r          = mk_res(1, CH_NUL, CH_NUL, CH_NUL);
            pred_count = '0;
        end
        else if (cnt + 1 < eff)
        begin
            if (unreserved(b))
            begin
                r          = mk_res(1, b, CH_NUL, CH_NUL);
                pred_count = pred_count + 12'd1;
            end
            else if (b == CH_SPACE)
            begin
                r          = mk_res(1, CH_PLUS, CH_NUL, CH_NUL);
                pred_count = pred_count + 12'd1;
            end
            else if (cnt + 4 < eff)
            begin
                r          = mk_res(3, CH_PERCENT, HEX_SET[b[7:4]], HEX_SET[b[3:0]]);
                pred_count = pred_count + 12'd3;
            end
        end
        return r;
    endfunction

    // Offers one byte, waits for the request to be taken and queues its encoding.
    // Called and returning at a falling edge; in_valid stays high on return.
    task automatic send_char(input logic [ByteW-1:0] b, input logic typed, input res_t want);
        res_t r;
        while ($urandom_range(99) < send_gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        char_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = encode_char(b);
        if (typed)
            r = want;
        for (int i = 0; i < int'(r.num); i++)
            pending_bytes.push_back('{ob: r.bytes[i], last: (i == int'(r.num) - 1)});
        sent_items++;
        @(negedge clk);
    endtask

    // Writes the capacity once the block has gone quiet; a dropped byte leaves no
    // result behind, so a drain wait follows the empty queue before the write.
    task automatic set_capacity(input logic [CapW-1:0] v);
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        capacity  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        pred_capacity = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver stalls at random on every falling edge.
    initial
    begin
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(99) < recv_pct);
        end
    end

    // Each accepted output byte is matched against the oldest expectation.
    always @(posedge clk)
    begin
        enc_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected output byte %02h run_last %0d",
                         $time, out_byte, run_last);
                error_count++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (out_byte !== want.ob)
                begin
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, want.ob, out_byte);
                    error_count++;
                end
                if (run_last !== want.last)
                begin
                    $display("%0t: run_last expected %0d actual %0d",
                             $time, want.last, run_last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("url_form_byte_encoder test failed");
        $finish;
    end

    // Stimulus: reset, directed table, then random string phases.
    initial
    begin
        int               start_items;
        int               phase_start;
        int               phase;
        int               len;
        logic [ByteW-1:0] ch;
        logic [CapW-1:0]  cap;

        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        capacity      = '0;
        in_valid      = 1'b0;
        char_byte     = '0;
        out_stall     = 1'b0;
        pred_capacity = CAPACITY_INIT;
        pred_count    = '0;
        error_count   = 0;
        sent_items    = 0;
        send_gap      = 0;
        recv_pct      = 0;

        // Reset capacity, then the extremes and every class of byte.
        dir_rows[0]  = '{CH_NUL,   1'b1, mk_res(1, CH_NUL, CH_NUL, CH_NUL)};
        dir_rows[1]  = '{CH_UA,    1'b1, mk_res(1, CH_UA, CH_NUL, CH_NUL)};
        dir_rows[2]  = '{CH_UZ,    1'b1, mk_res(1, CH_UZ, CH_NUL, CH_NUL)};
        dir_rows[3]  = '{CH_LA,    1'b1, mk_res(1, CH_LA, CH_NUL, CH_NUL)};
        dir_rows[4]  = '{CH_LZ,    1'b1, mk_res(1, CH_LZ, CH_NUL, CH_NUL)};
        dir_rows[5]  = '{CH_ZERO,  1'b1, mk_res(1, CH_ZERO, CH_NUL, CH_NUL)};
        dir_rows[6]  = '{CH_NINE,  1'b1, mk_res(1, CH_NINE, CH_NUL, CH_NUL)};
        dir_rows[7]  = '{CH_DASH,  1'b1, mk_res(1, CH_DASH, CH_NUL, CH_NUL)};
        dir_rows[8]  = '{CH_UNDER, 1'b1, mk_res(1, CH_UNDER, CH_NUL, CH_NUL)};
        dir_rows[9]  = '{CH_DOT,   1'b1, mk_res(1, CH_DOT, CH_NUL, CH_NUL)};
        dir_rows[10] = '{CH_TILDE, 1'b1, mk_res(1, CH_TILDE, CH_NUL, CH_NUL)};
        dir_rows[11] = '{CH_SPACE, 1'b1, mk_res(1, CH_PLUS, CH_NUL, CH_NUL)};
        dir_rows[12] = '{8'hFF,    1'b1, mk_res(3, CH_PERCENT, CH_UF, CH_UF)};
        dir_rows[13] = '{8'h80,    1'b1, mk_res(3, CH_PERCENT, 8'h38, CH_ZERO)};
        dir_rows[14] = '{8'h01,    1'b1, mk_res(3, CH_PERCENT, CH_ZERO, 8'h31)};
        dir_rows[15] = '{8'h7F,    1'b0, '0};
        dir_rows[16] = '{8'h2F,    1'b0, '0};
        dir_rows[17] = '{8'h40,    1'b0, '0};
        dir_rows[18] = '{8'h5B,    1'b0, '0};
        dir_rows[19] = '{8'h60,    1'b0, '0};
        dir_rows[20] = '{8'h7B,    1'b0, '0};
        dir_rows[21] = '{8'h3A,    1'b0, '0};
        dir_rows[22] = '{CH_NUL,   1'b1, mk_res(1, CH_NUL, CH_NUL, CH_NUL)};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_char(dir_rows[i].ch, dir_rows[i].typed, dir_rows[i].want);

        // Random phases: mostly terminated strings, some left open across a
        // capacity change; the idle pattern rotates from phase to phase.
        start_items = sent_items;
        phase       = 0;
        while (sent_items - start_items < TARGET_ITEMS)
        begin
            if (phase < EDGE_COUNT)
                cap = EDGE_CAPS[phase];
            else
            begin
                case ($urandom_range(9)) inside
                    [0:5]:   cap = 13'($urandom_range(40));
                    6:       cap = 13'($urandom_range(300, 41));
                    7:       cap = 13'($urandom);
                    8:       cap = MAX_CAPACITY;
                    default: cap = 13'h1FFF;
                endcase
            end
            set_capacity(cap);
            case (phase % 4)
                0:
                begin
                    send_gap = 0;
                    recv_pct = 0;
                end
                1:
                begin
                    send_gap = 47;
                    recv_pct = 0;
                end
                2:
                begin
                    send_gap = 0;
                    recv_pct = 47;
                end
                default:
                begin
                    send_gap = 33;
                    recv_pct = 33;
                end
            endcase
            phase_start = sent_items;
            while (sent_items - phase_start < PHASE_ITEMS)
            begin
                len = ($urandom_range(7) == 0) ? $urandom_range(60) : $urandom_range(12);
                for (int k = 0; k < len; k++)
                begin
                    case ($urandom_range(9)) inside
                        [0:3]:   ch = PLAIN_SET[$urandom_range(PLAIN_SET.len() - 1)];
                        4:       ch = CH_SPACE;
                        [5:7]:   ch = 8'($urandom_range(255, 1));
                        default: ch = 8'($urandom_range(255, 128));
                    endcase
                    send_char(ch, 1'b0, '0);
                end
                if ($urandom_range(99) >= 15)
                    send_char(CH_NUL, 1'b0, '0);
            end
            phase++;
        end

        // Let every expected byte arrive, then wait a drain period for strays.
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("url_form_byte_encoder test passed");
        else
            $display("url_form_byte_encoder test failed");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/url_enc_pkg.sv
hw/rtl/url_enc_encode.sv
hw/rtl/url_enc_outbuf.sv
hw/rtl/url_form_byte_encoder.sv
hw/rtl/url_enc_checker.sv
bench/url_form_byte_encoder_test.sv
